// ----- rtl/swzd_pkg.sv -----
// Shared constants for the sliding-window z-score detector.
// Used by the square-root unit, the divider unit and the top level.
package swzd_pkg;
    localparam int CHANNELS  = 16;
    localparam int WINDOW    = 32;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int ADDR_W    = CH_W + SLOT_W;
    localparam int DEPTH     = CHANNELS * WINDOW;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 21;
    localparam int SQS_W     = 38;
    localparam int D_W       = FILL_W + SQS_W;
    localparam int ROOT_W    = D_W / 2;
    localparam int DEV_W     = FILL_W + SAMPLE_W;
    localparam int NUM_W     = DEV_W + 8;
    localparam int SCL_W     = D_W + 14;
    localparam int THR_W     = 16;
    localparam logic [THR_W-1:0]  THR_RESET = 16'd768;
    localparam logic [FILL_W-1:0] WARMUP    = FILL_W'(5);
endpackage

// ----- rtl/swzd_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Depends on swzd_pkg for operand widths.
module swzd_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swzd_pkg::D_W-1:0]      i_value,
    output logic                          o_done,
    output logic [swzd_pkg::ROOT_W-1:0]   o_root
);
    localparam int CNT_W = $clog2(swzd_pkg::ROOT_W + 1);

    logic [swzd_pkg::D_W-1:0] r_rem;
    logic [swzd_pkg::D_W-1:0] r_root;
    logic [swzd_pkg::D_W-1:0] r_bit;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_done;
    logic [swzd_pkg::D_W:0]   w_trial;

    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_rem  <= i_value;
                r_root <= '0;
                r_bit  <= swzd_pkg::D_W'(1) << (2 * (swzd_pkg::ROOT_W - 1));
                r_cnt  <= CNT_W'(swzd_pkg::ROOT_W);
            end else if (r_cnt != '0) begin
                if ({1'b0, r_rem} >= w_trial) begin
                    r_rem  <= r_rem - w_trial[swzd_pkg::D_W-1:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[swzd_pkg::ROOT_W-1:0];

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("root done held");
endmodule

// ----- rtl/swzd_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on swzd_pkg for operand widths.
module swzd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swzd_pkg::NUM_W-1:0]    i_num,
    input  logic [swzd_pkg::ROOT_W-1:0]   i_den,
    output logic                          o_done,
    output logic [swzd_pkg::NUM_W-1:0]    o_quo
);
    localparam int CNT_W = $clog2(swzd_pkg::NUM_W + 1);
    localparam int REM_W = swzd_pkg::ROOT_W + 1;

    logic [REM_W-1:0]               r_rem;
    logic [swzd_pkg::NUM_W-1:0]     r_quo;
    logic [swzd_pkg::ROOT_W-1:0]    r_den;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_done;
    logic [REM_W-1:0]               w_shift;
    logic                           w_ge;

    assign w_shift = {r_rem[REM_W-2:0], r_quo[swzd_pkg::NUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_rem <= '0;
                r_quo <= i_num;
                r_den <= i_den;
                r_cnt <= CNT_W'(swzd_pkg::NUM_W);
            end else if (r_cnt != '0) begin
                r_rem <= w_ge ? w_shift - {1'b0, r_den} : w_shift;
                r_quo <= {r_quo[swzd_pkg::NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_rem < {1'b0, r_den})) else $error("remainder overflow");
endmodule

// ----- rtl/sliding_window_zscore_detector.sv -----
// Sliding-window z-score detector: a request passes the read, square, update, multiply,
// difference, scale and test states; windows past warm-up with enough variance then add a 22-step
// root and a 30-step divide before the result is registered. One item at a time; a result
// waits for a free output, and the next request is taken the cycle after it is registered.
// Reset (synchronous, active low) clears fill counts, slots, sums and sets the
// threshold to 3.0; the sample memory is not cleared and needs no clearing pass.
module sliding_window_zscore_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] channel, [19:4] sample, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] channel_out, [19:4] score, rest zero
    output logic [1:0]  m_axis_tuser    // [0] anomaly, [1] warming_up
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_SQ, ST_UPD, ST_MUL, ST_DIF, ST_SCL, ST_TST,
        ST_SQRT, ST_DIV, ST_FIN
    } t_state;

    t_state                              r_state;
    logic [swzd_pkg::SAMPLE_W-1:0]       r_mem [swzd_pkg::DEPTH];
    logic [swzd_pkg::SAMPLE_W-1:0]       r_mem_q;
    logic [swzd_pkg::FILL_W-1:0]         r_fill [swzd_pkg::CHANNELS];
    logic [swzd_pkg::SLOT_W-1:0]         r_slot [swzd_pkg::CHANNELS];
    logic [swzd_pkg::SUM_W-1:0]          r_sum  [swzd_pkg::CHANNELS];
    logic [swzd_pkg::SQS_W-1:0]          r_sqs  [swzd_pkg::CHANNELS];
    logic [swzd_pkg::THR_W-1:0]          r_thr;
    logic [3:0]                          r_raw_ch;
    logic [swzd_pkg::CH_W-1:0]           r_ch;
    logic [swzd_pkg::ADDR_W-1:0]         r_addr;
    logic [swzd_pkg::SAMPLE_W-1:0]       r_x;
    logic [31:0]                         r_old2;
    logic [31:0]                         r_x2;
    logic [swzd_pkg::FILL_W-1:0]         r_n;
    logic [swzd_pkg::SUM_W-1:0]          r_s;
    logic [swzd_pkg::SQS_W-1:0]          r_q;
    logic [swzd_pkg::D_W-1:0]            r_nq;
    logic [2*swzd_pkg::SUM_W-1:0]        r_s2;
    logic [swzd_pkg::DEV_W-1:0]          r_nx;
    logic [2*swzd_pkg::FILL_W-1:0]       r_n2;
    logic [swzd_pkg::D_W-1:0]            r_d;
    logic [swzd_pkg::DEV_W-1:0]          r_dev;
    logic [swzd_pkg::SCL_W-1:0]          r_dk;
    logic                                r_sqrt_go;
    logic                                r_div_go;
    logic                                r_out_valid;
    logic [3:0]                          r_out_ch;
    logic [15:0]                         r_out_score;
    logic                                r_out_anom;
    logic                                r_out_warm;
    logic [15:0]                         r_score;

    logic [swzd_pkg::CH_W-1:0]           w_in_ch;
    logic                                w_full;
    logic [swzd_pkg::SAMPLE_W-1:0]       w_old;
    logic [swzd_pkg::SUM_W-1:0]          w_new_s;
    logic [swzd_pkg::SQS_W-1:0]          w_new_q;
    logic [swzd_pkg::D_W:0]              w_s2x;
    logic                                w_root_done;
    logic [swzd_pkg::ROOT_W-1:0]         w_root;
    logic [swzd_pkg::ROOT_W-1:0]         w_den;
    logic                                w_div_done;
    logic [swzd_pkg::NUM_W-1:0]          w_quo;
    logic                                w_out_free;

    assign w_in_ch    = s_axis_tdata[swzd_pkg::CH_W-1:0];
    assign w_full     = r_fill[r_ch] >= swzd_pkg::FILL_W'(swzd_pkg::WINDOW);
    assign w_old      = w_full ? r_mem_q : '0;
    assign w_new_s    = r_sum[r_ch] - swzd_pkg::SUM_W'(w_old) + swzd_pkg::SUM_W'(r_x);
    assign w_new_q    = r_sqs[r_ch] - swzd_pkg::SQS_W'(r_old2) + swzd_pkg::SQS_W'(r_x2);
    assign w_s2x      = {(swzd_pkg::D_W + 1 - 2 * swzd_pkg::SUM_W)'(0), r_s2};
    assign w_den      = (w_root == '0) ? swzd_pkg::ROOT_W'(1) : w_root;
    assign w_out_free = !r_out_valid || m_axis_tready;

    swzd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_go),
        .i_value (r_d),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    swzd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   ({r_dev, 8'd0}),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Sample memory: one read port, one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_mem_q <= r_mem[{w_in_ch, r_slot[w_in_ch]}];
        end
        if (r_state == ST_UPD) begin
            r_mem[r_addr] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= swzd_pkg::THR_RESET;
            r_out_valid <= 1'b0;
            r_sqrt_go   <= 1'b0;
            r_div_go    <= 1'b0;
            for (int i = 0; i < swzd_pkg::CHANNELS; i++) begin
                r_fill[i] <= '0;
                r_slot[i] <= '0;
                r_sum[i]  <= '0;
                r_sqs[i]  <= '0;
            end
        end else begin
            r_sqrt_go <= (r_state == ST_TST) && (r_n >= swzd_pkg::WARMUP)
                         && (r_dk > (swzd_pkg::SCL_W'(r_n2) << 16));
            r_div_go  <= (r_state == ST_SQRT) && w_root_done;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            // In the final state a new result replaces the one being taken.
            if (r_out_valid && m_axis_tready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_raw_ch <= s_axis_tdata[3:0];
                        r_ch     <= w_in_ch;
                        r_addr   <= {w_in_ch, r_slot[w_in_ch]};
                        r_x      <= s_axis_tdata[19:4];
                        r_state  <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_old2  <= w_old * w_old;
                    r_x2    <= r_x * r_x;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_sum[r_ch] <= w_new_s;
                    r_sqs[r_ch] <= w_new_q;
                    r_s         <= w_new_s;
                    r_q         <= w_new_q;
                    r_n         <= w_full ? r_fill[r_ch] : r_fill[r_ch] + 1'b1;
                    if (!w_full) begin
                        r_fill[r_ch] <= r_fill[r_ch] + 1'b1;
                    end
                    r_slot[r_ch] <= (r_slot[r_ch] == swzd_pkg::SLOT_W'(swzd_pkg::WINDOW - 1))
                                    ? '0 : r_slot[r_ch] + 1'b1;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_nq    <= r_n * r_q;
                    r_s2    <= r_s * r_s;
                    r_nx    <= r_n * r_x;
                    r_n2    <= r_n * r_n;
                    r_state <= ST_DIF;
                end
                ST_DIF: begin
                    r_d     <= ({1'b0, r_nq} > w_s2x) ? r_nq - w_s2x[swzd_pkg::D_W-1:0] : '0;
                    r_dev   <= (r_nx >= swzd_pkg::DEV_W'(r_s)) ? r_nx - swzd_pkg::DEV_W'(r_s)
                               : swzd_pkg::DEV_W'(r_s) - r_nx;
                    r_state <= ST_SCL;
                end
                ST_SCL: begin
                    // 10000 = 8192 + 1024 + 512 + 256 + 16
                    r_dk <= (swzd_pkg::SCL_W'(r_d) << 13) + (swzd_pkg::SCL_W'(r_d) << 10)
                          + (swzd_pkg::SCL_W'(r_d) << 9) + (swzd_pkg::SCL_W'(r_d) << 8)
                          + (swzd_pkg::SCL_W'(r_d) << 4);
                    r_state <= ST_TST;
                end
                ST_TST: begin
                    r_score <= '0;
                    if (r_n < swzd_pkg::WARMUP) begin
                        r_state <= ST_FIN;
                    end else if (r_dk > (swzd_pkg::SCL_W'(r_n2) << 16)) begin
                        r_state <= ST_SQRT;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_SQRT: begin
                    if (w_root_done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_score <= (w_quo > swzd_pkg::NUM_W'(16'hFFFF)) ? 16'hFFFF
                                   : w_quo[15:0];
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ch    <= r_raw_ch;
                        r_out_score <= r_score;
                        r_out_warm  <= r_n < swzd_pkg::WARMUP;
                        r_out_anom  <= (r_n >= swzd_pkg::WARMUP) && (r_score > r_thr);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_score, r_out_ch};
    assign m_axis_tuser  = {r_out_warm, r_out_anom};

    a_busy_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("request taken while busy");
    a_warm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_warm) |-> (r_out_score == '0 && !r_out_anom))
        else $error("warm-up result not zero");
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_n <= swzd_pkg::FILL_W'(swzd_pkg::WINDOW)))
        else $error("fill overflow");
endmodule
